[rtl/bsm_pkg.sv]
`timescale 1ns / 1ps

package bsm_pkg;

	localparam int ROM_BANK_BITS_DEF = 7;
	localparam int RAM_BANK_BITS_DEF = 2;
	localparam int ROM_BANK_FULL_W   = 7;
	localparam int ROM_LOW_W         = 5;
	localparam int ROM_WIN_W         = 14;
	localparam int RAM_WIN_W         = 13;
	localparam int MEM_ADDR_W        = 21;

	localparam logic [15:0] BANK_RAMEN_END = 16'h2000;
	localparam logic [15:0] BANK_ROMLO_END = 16'h4000;
	localparam logic [15:0] BANK_ROMHI_END = 16'h6000;
	localparam logic [15:0] BANK_AREA_END  = 16'h8000;
	localparam logic [15:0] ROM_SW_LO      = 16'h4000;
	localparam logic [15:0] CART_RAM_LO    = 16'hA000;
	localparam logic [15:0] CART_RAM_END   = 16'hC000;
	localparam logic [15:0] ECHO_LO        = 16'hE000;
	localparam logic [15:0] ECHO_END       = 16'hFE00;
	localparam logic [15:0] ECHO_OFFSET    = 16'h2000;
	localparam logic [15:0] UNUSABLE_LO    = 16'hFEA0;
	localparam logic [15:0] UNUSABLE_END   = 16'hFF00;
	localparam logic [15:0] DIV_ADDR       = 16'hFF04;
	localparam logic [15:0] LY_ADDR        = 16'hFF44;

	localparam logic [3:0] RAM_ENABLE_CODE  = 4'hA;
	localparam logic [3:0] RAM_DISABLE_CODE = 4'h0;

	typedef enum logic {
		ACCESS_READ  = 1'b0,
		ACCESS_WRITE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		REGION_INTERNAL = 2'd0,
		REGION_ROM      = 2'd1,
		REGION_RAM      = 2'd2
	} region_t;

	typedef enum logic [1:0] {
		COUNT_NONE = 2'd0,
		COUNT_ONE  = 2'd1,
		COUNT_TWO  = 2'd2
	} count_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] address;
		logic [7:0]  data;
	} in_word_t;

	typedef struct packed {
		logic                  is_write;
		region_t               region;
		logic [MEM_ADDR_W-1:0] mem_address;
		logic [7:0]            write_byte;
		logic                  last;
	} out_word_t;

	typedef struct packed {
		count_t    count;
		logic      bank_wr;
		out_word_t first;
		out_word_t second;
	} xlate_t;

endpackage

[rtl/bsm_chan_if.sv]
`timescale 1ns / 1ps

interface bsm_chan_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/bsm_bank_regs.sv]
`timescale 1ns / 1ps

module bsm_bank_regs #(
	parameter int ROM_BANK_BITS = bsm_pkg::ROM_BANK_BITS_DEF,
	parameter int RAM_BANK_BITS = bsm_pkg::RAM_BANK_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [15:0]              address,
	input  logic [7:0]               data,
	output logic                     ram_enable,
	output logic [ROM_BANK_BITS-1:0] rom_bank,
	output logic [RAM_BANK_BITS-1:0] ram_bank
);
	import bsm_pkg::*;

	logic                       ram_enable_q;
	logic [ROM_BANK_BITS-1:0]   rom_bank_q;
	logic [RAM_BANK_BITS-1:0]   ram_bank_q;
	logic                       mode_q;

	logic [ROM_BANK_FULL_W-1:0] rom_full;
	logic [ROM_BANK_BITS-1:0]   rom_trunc;
	logic [ROM_BANK_BITS-1:0]   rom_next;

	always_comb begin
		rom_full = ROM_BANK_FULL_W'(rom_bank_q);
		if (address < BANK_ROMLO_END) begin
			rom_full[ROM_LOW_W-1:0] = data[ROM_LOW_W-1:0];
		end else begin
			rom_full[ROM_BANK_FULL_W-1:ROM_LOW_W] = data[1:0];
		end
		rom_trunc = rom_full[ROM_BANK_BITS-1:0];
		rom_next  = (rom_trunc == '0) ? ROM_BANK_BITS'(1) : rom_trunc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enable_q <= 1'b0;
			rom_bank_q   <= ROM_BANK_BITS'(1);
			ram_bank_q   <= '0;
			mode_q       <= 1'b0;
		end else if (wr_en) begin
			priority if (address < BANK_RAMEN_END) begin
				if (data[3:0] == RAM_ENABLE_CODE) begin
					ram_enable_q <= 1'b1;
				end else if (data[3:0] == RAM_DISABLE_CODE) begin
					ram_enable_q <= 1'b0;
				end
			end else if (address < BANK_ROMLO_END) begin
				rom_bank_q <= rom_next;
			end else if (address < BANK_ROMHI_END) begin
				if (!mode_q) begin
					rom_bank_q <= rom_next;
				end else begin
					ram_bank_q <= data[RAM_BANK_BITS-1:0];
				end
			end else begin
				mode_q <= data[0];
				if (!data[0]) begin
					ram_bank_q <= '0;
				end
			end
		end
	end

	assign ram_enable = ram_enable_q;
	assign rom_bank   = rom_bank_q;
	assign ram_bank   = ram_bank_q;
endmodule

[rtl/bsm_translate.sv]
`timescale 1ns / 1ps

module bsm_translate #(
	parameter int ROM_BANK_BITS = bsm_pkg::ROM_BANK_BITS_DEF,
	parameter int RAM_BANK_BITS = bsm_pkg::RAM_BANK_BITS_DEF
) (
	input  bsm_pkg::in_word_t        item,
	input  logic                     ram_enable,
	input  logic [ROM_BANK_BITS-1:0] rom_bank,
	input  logic [RAM_BANK_BITS-1:0] ram_bank,
	output bsm_pkg::xlate_t          xl
);
	import bsm_pkg::*;

	logic [15:0]           a;
	logic                  in_rom;
	logic                  in_ram;
	logic                  in_echo;
	logic                  in_unusable;
	logic [MEM_ADDR_W-1:0] rom_addr;
	logic [MEM_ADDR_W-1:0] ram_addr;
	logic [MEM_ADDR_W-1:0] int_addr;
	logic [MEM_ADDR_W-1:0] echo_addr;

	always_comb begin
		a           = item.address;
		in_rom      = (a >= ROM_SW_LO) && (a < BANK_AREA_END);
		in_ram      = (a >= CART_RAM_LO) && (a < CART_RAM_END);
		in_echo     = (a >= ECHO_LO) && (a < ECHO_END);
		in_unusable = (a >= UNUSABLE_LO) && (a < UNUSABLE_END);
		rom_addr    = MEM_ADDR_W'({rom_bank, a[ROM_WIN_W-1:0]});
		ram_addr    = MEM_ADDR_W'({ram_bank, a[RAM_WIN_W-1:0]});
		int_addr    = MEM_ADDR_W'(a);
		echo_addr   = MEM_ADDR_W'(a - ECHO_OFFSET);

		xl.count   = COUNT_ONE;
		xl.bank_wr = 1'b0;

		xl.first.is_write    = 1'b0;
		xl.first.region      = REGION_INTERNAL;
		xl.first.mem_address = int_addr;
		xl.first.write_byte  = '0;
		xl.first.last        = 1'b1;

		xl.second.is_write    = 1'b1;
		xl.second.region      = REGION_INTERNAL;
		xl.second.mem_address = echo_addr;
		xl.second.write_byte  = item.data;
		xl.second.last        = 1'b1;

		if (item.kind == ACCESS_READ) begin
			if (in_rom) begin
				xl.first.region      = REGION_ROM;
				xl.first.mem_address = rom_addr;
			end else if (in_ram) begin
				xl.first.region      = REGION_RAM;
				xl.first.mem_address = ram_addr;
			end
		end else begin
			xl.first.is_write   = 1'b1;
			xl.first.write_byte = item.data;
			priority if (a < BANK_AREA_END) begin
				xl.count   = COUNT_NONE;
				xl.bank_wr = 1'b1;
			end else if (in_ram) begin
				xl.count             = ram_enable ? COUNT_ONE : COUNT_NONE;
				xl.first.region      = REGION_RAM;
				xl.first.mem_address = ram_addr;
			end else if (in_echo) begin
				xl.count      = COUNT_TWO;
				xl.first.last = 1'b0;
			end else if (in_unusable) begin
				xl.count = COUNT_NONE;
			end else if ((a == DIV_ADDR) || (a == LY_ADDR)) begin
				xl.first.write_byte = '0;
			end else begin
				xl.count = COUNT_ONE;
			end
		end
	end
endmodule

[rtl/bank_switching_memory_mapper.sv]
`timescale 1ns / 1ps
// A bus word is held in the input reg, translated, and its result word leaves from the result reg.
// Throughput: 1 bus word per cycle while mem takes results; an echo-area write holds the input
// until the result register has carried both of its writes out, one per cycle.
// Bank register writes land at the end of their cycle and steer the next word.
// Reset (arst_n low, async): pipeline empty, RAM off, ROM bank 1, RAM bank 0, ROM mode.

module bank_switching_memory_mapper #(
	parameter int ROM_BANK_BITS = bsm_pkg::ROM_BANK_BITS_DEF,
	parameter int RAM_BANK_BITS = bsm_pkg::RAM_BANK_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bsm_chan_if.sink   bus,
	bsm_chan_if.source mem
);
	import bsm_pkg::*;

	logic                     valid_s1;
	in_word_t                 item_s1;
	logic                     phase_q;
	logic                     out_valid_q;
	out_word_t                out_q;

	xlate_t                   xl;
	logic                     ram_enable;
	logic [ROM_BANK_BITS-1:0] rom_bank;
	logic [RAM_BANK_BITS-1:0] ram_bank;

	logic                     emit;
	logic                     can_load;
	logic                     load_out;
	logic                     advance;
	logic                     take_in;

	bsm_bank_regs #(
		.ROM_BANK_BITS(ROM_BANK_BITS),
		.RAM_BANK_BITS(RAM_BANK_BITS)
	) u_bank_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (advance && xl.bank_wr),
		.address   (item_s1.address),
		.data      (item_s1.data),
		.ram_enable(ram_enable),
		.rom_bank  (rom_bank),
		.ram_bank  (ram_bank)
	);

	bsm_translate #(
		.ROM_BANK_BITS(ROM_BANK_BITS),
		.RAM_BANK_BITS(RAM_BANK_BITS)
	) u_translate (
		.item      (item_s1),
		.ram_enable(ram_enable),
		.rom_bank  (rom_bank),
		.ram_bank  (ram_bank),
		.xl        (xl)
	);

	always_comb begin
		emit     = valid_s1 && (xl.count != COUNT_NONE);
		can_load = !out_valid_q || mem.ready;
		load_out = emit && can_load;
		advance  = valid_s1 && ((xl.count == COUNT_NONE) ||
			(can_load && ((xl.count == COUNT_ONE) || phase_q)));
		take_in  = bus.valid && bus.ready;
	end

	assign bus.ready   = !valid_s1 || advance;
	assign mem.valid   = out_valid_q;
	assign mem.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q <= 1'b0;
			end else if (load_out) begin
				phase_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (mem.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= bus.payload;
		end
		if (load_out) begin
			out_q <= phase_q ? xl.second : xl.first;
		end
	end
endmodule

[rtl/bsm_checker.sv]
`timescale 1ns / 1ps

module bsm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               mem_valid,
	input logic               mem_ready,
	input bsm_pkg::out_word_t mem_payload
);
	import bsm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mem_valid && !mem_ready |=> mem_valid && $stable(mem_payload))
		else $error("result word changed while stalled");

	a_read_shape: assert property (@(posedge clk) disable iff (!arst_n)
		mem_valid && !mem_payload.is_write |->
			mem_payload.last && (mem_payload.write_byte == '0))
		else $error("read request not single or carries a byte");

	a_echo_pair: assert property (@(posedge clk) disable iff (!arst_n)
		mem_valid && mem_ready && !mem_payload.last |=>
			mem_valid && mem_payload.last && mem_payload.is_write &&
			(mem_payload.region == REGION_INTERNAL))
		else $error("echo write not followed by its mirror write");

	a_first_internal: assert property (@(posedge clk) disable iff (!arst_n)
		mem_valid && !mem_payload.last |->
			mem_payload.is_write && (mem_payload.region == REGION_INTERNAL) &&
			(mem_payload.mem_address[15:13] == 3'b111))
		else $error("non-final word outside echo area");
endmodule

bind bank_switching_memory_mapper bsm_checker u_bsm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.mem_valid  (mem.valid),
	.mem_ready  (mem.ready),
	.mem_payload(mem.payload)
);
